@@ rtl/modular_exponentiation_unit_defines.svh @@
// Assertion macros shared by the modular exponentiation unit.
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define MEXP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mexp_pkg.sv @@
// Shared constants, types and controller/datapath interface for modular exponentiation.
package mexp_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int CNT_W        = $clog2(OPERAND_BITS);

    localparam logic [OPERAND_BITS-1:0] MODULUS_RESET = OPERAND_BITS'(1000000007);

    typedef logic [OPERAND_BITS-1:0] operand_t;

    // Which multiplication the shared shift-add unit performs
    typedef enum logic [1:0] {
        MUL_OP_REDUCE,
        MUL_OP_ACC,
        MUL_OP_SQUARE
    } mul_op_t;

    typedef struct packed {
        logic    load_item;
        logic    mul_start;
        logic    mul_step;
        logic    write_back;
        logic    shift_exp;
        logic    load_result;
        mul_op_t op;
    } mexp_cmd_t;

    typedef struct packed {
        logic mul_last;
        logic exp_zero;
        logic exp_lsb;
    } mexp_status_t;

endpackage

@@ rtl/modular_exponentiation_unit.sv @@
// Top level: base^exponent mod modulus by right-to-left square-and-multiply.
//
// Input channel s_valid/s_ready carries s_base_value and s_exponent; an item is
// taken when both are high. Result channel m_valid/m_ready carries m_power_result.
// The modulus register is written by cfg_wr_en/cfg_wr_data; the user must write
// it only while the unit is idle, which the block itself does not enforce.
// A modulus of 0 acts as 1, and a zero exponent returns 1 without reduction.
// One serial shift-add multiplier handles every product, one multiplier bit per
// cycle. The unit first reduces the base, then for each exponent bit up to its
// highest set one squares when the bit is 0, or multiplies and then squares when
// it is 1, and finally presents the result. One item is in work at a time.
// A new item is accepted as soon as the previous result is in the output
// register, even if the receiver has not yet taken it. If m_ready stays low,
// the next item finishes and then waits until the output register is free.
// Reset (aresetn low, synchronous) empties the output, returns the controller
// to idle and sets the modulus to 1000000007.
module modular_exponentiation_unit import mexp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cfg_wr_en,
    input  operand_t cfg_wr_data,
    input  logic     s_valid,
    output logic     s_ready,
    input  operand_t s_base_value,
    input  operand_t s_exponent,
    output logic     m_valid,
    input  logic     m_ready,
    output operand_t m_power_result
);

    mexp_cmd_t    cmd;
    mexp_status_t status;

    mexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status_i (status),
        .cmd_o    (cmd)
    );

    mexp_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_base_value (s_base_value),
        .s_exponent   (s_exponent),
        .cmd_i        (cmd),
        .status_o     (status),
        .result_o     (m_power_result)
    );

endmodule

@@ rtl/mexp_datapath.sv @@
// Datapath: operand registers, modulus register and the serial modular multiplier.
`include "modular_exponentiation_unit_defines.svh"

module mexp_datapath import mexp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  operand_t     cfg_wr_data,
    input  operand_t     s_base_value,
    input  operand_t     s_exponent,
    input  mexp_cmd_t    cmd_i,
    output mexp_status_t status_o,
    output operand_t     result_o
);

    operand_t             modulus_reg;
    operand_t             acc_reg, acc_next;
    operand_t             sq_reg, sq_next;
    operand_t             exp_reg, exp_next;
    operand_t             prod_reg, prod_next;
    operand_t             mplier_reg, mplier_next;
    operand_t             result_reg, result_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    operand_t             m_eff;
    operand_t             mul_x;
    logic [OPERAND_BITS:0] m_ext, dbl, dbl_red, sum, sum_red;

    // A zero modulus behaves as one
    assign m_eff = (modulus_reg == '0) ? operand_t'(1) : modulus_reg;
    assign m_ext = {1'b0, m_eff};

    always_comb begin
        case (cmd_i.op)
            MUL_OP_REDUCE: mul_x = operand_t'(1);
            MUL_OP_ACC:    mul_x = acc_reg;
            MUL_OP_SQUARE: mul_x = sq_reg;
            default:       mul_x = '0;
        endcase
    end

    // One multiplier bit per cycle, MSB first: prod = 2*prod + bit*x, kept below m.
    // x never exceeds m, so each partial sum stays below 2m.
    always_comb begin
        dbl     = {prod_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum     = dbl_red + (mplier_reg[OPERAND_BITS-1] ? {1'b0, mul_x} : '0);
        sum_red = (sum >= m_ext) ? sum - m_ext : sum;
    end

    always_comb begin
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        exp_next    = exp_reg;
        prod_next   = prod_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;

        if (cmd_i.load_item) begin
            acc_next = operand_t'(1);
            sq_next  = s_base_value;
            exp_next = s_exponent;
        end
        if (cmd_i.mul_start) begin
            prod_next   = '0;
            mplier_next = sq_reg;
            cnt_next    = CNT_W'(OPERAND_BITS - 1);
        end
        if (cmd_i.mul_step) begin
            prod_next   = sum_red[OPERAND_BITS-1:0];
            mplier_next = {mplier_reg[OPERAND_BITS-2:0], 1'b0};
            cnt_next    = cnt_reg - CNT_W'(1);
        end
        if (cmd_i.write_back) begin
            case (cmd_i.op)
                MUL_OP_ACC: acc_next = sum_red[OPERAND_BITS-1:0];
                default:    sq_next  = sum_red[OPERAND_BITS-1:0];
            endcase
        end
        if (cmd_i.shift_exp) begin
            exp_next = exp_reg >> 1;
        end
        if (cmd_i.load_result) begin
            result_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
        end else if (cfg_wr_en) begin
            modulus_reg <= cfg_wr_data;
        end
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        exp_reg    <= exp_next;
        prod_reg   <= prod_next;
        mplier_reg <= mplier_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign status_o.mul_last = (cnt_reg == '0);
    assign status_o.exp_zero = (exp_reg == '0);
    assign status_o.exp_lsb  = exp_reg[0];
    assign result_o          = result_reg;

    `MEXP_ASSERT_NEXT(a_prod_reduced, cmd_i.mul_step, prod_reg < m_eff,
        "partial product not reduced below modulus")
    `MEXP_ASSERT_NEXT(a_square_reduced, cmd_i.write_back, sq_reg < m_eff,
        "running square not reduced after write-back")
    `MEXP_ASSERT_NEXT(a_acc_init, cmd_i.load_item, acc_reg == operand_t'(1),
        "accumulator not initialized to one")

endmodule

@@ rtl/mexp_ctrl.sv @@
// Controller: sequences base reduction and square-and-multiply over exponent bits.
`include "modular_exponentiation_unit_defines.svh"

module mexp_ctrl import mexp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  mexp_status_t status_i,
    output mexp_cmd_t    cmd_o
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_START,
        ST_MUL_RUN,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;
    logic    out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd_o          = '0;
        cmd_o.op       = op_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_o.load_item = 1'b1;
                    op_next         = MUL_OP_REDUCE;
                    state_next      = ST_MUL_START;
                end
            end
            ST_MUL_START: begin
                cmd_o.mul_start = 1'b1;
                state_next      = ST_MUL_RUN;
            end
            ST_MUL_RUN: begin
                cmd_o.mul_step = 1'b1;
                if (status_i.mul_last) begin
                    cmd_o.write_back = 1'b1;
                    if (op_reg == MUL_OP_ACC) begin
                        op_next    = MUL_OP_SQUARE;
                        state_next = ST_MUL_START;
                    end else begin
                        cmd_o.shift_exp = (op_reg == MUL_OP_SQUARE);
                        state_next      = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (status_i.exp_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    op_next    = status_i.exp_lsb ? MUL_OP_ACC : MUL_OP_SQUARE;
                    state_next = ST_MUL_START;
                end
            end
            ST_FINISH: begin
                // wait for the output register to drain
                if (!out_valid_reg || m_ready) begin
                    cmd_o.load_result = 1'b1;
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= MUL_OP_REDUCE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    `MEXP_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
        "input still ready right after taking an item")
    `MEXP_ASSERT_NEXT(a_result_shown, cmd_o.load_result, m_valid,
        "result loaded but not presented")
    `MEXP_ASSERT_NEXT(a_mul_runs_through, cmd_o.mul_step && !status_i.mul_last,
        cmd_o.mul_step, "multiplication stopped before its last bit")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the modular exponentiation unit: scoreboard class and stimulus.

typedef struct packed {
    mexp_pkg::operand_t base_value;
    mexp_pkg::operand_t exponent;
    mexp_pkg::operand_t modulus;
    mexp_pkg::operand_t power;
} power_case_t;

class power_scoreboard;
    mexp_pkg::operand_t modulus;
    power_case_t expected_powers[$];
    int mismatches;
    int results_checked;
    int items_noted;

    function new();
        modulus = mexp_pkg::MODULUS_RESET;
        mismatches = 0;
        results_checked = 0;
        items_noted = 0;
    endfunction

    function void set_modulus(mexp_pkg::operand_t value);
        modulus = value;
    endfunction

    // right-to-left square-and-multiply at 64-bit width; m < 2^31 keeps products exact
    function mexp_pkg::operand_t power_mod(mexp_pkg::operand_t b, mexp_pkg::operand_t e);
        longint unsigned m;
        longint unsigned acc;
        longint unsigned sq;
        mexp_pkg::operand_t rest;
        m = (modulus == '0) ? 64'd1 : 64'(modulus);
        acc = 64'd1;    // zero exponent leaves 1, unreduced
        sq = 64'(b) % m;
        rest = e;
        while (rest != '0) begin
            if (rest[0]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            rest = rest >> 1;
        end
        return mexp_pkg::operand_t'(acc);
    endfunction

    function void note_item(mexp_pkg::operand_t b, mexp_pkg::operand_t e);
        power_case_t c;
        c.base_value = b;
        c.exponent = e;
        c.modulus = modulus;
        c.power = power_mod(b, e);
        expected_powers.push_back(c);
        items_noted++;
    endfunction

    task report_mismatch(string what);
        if (mismatches < 40) $display("ERROR %s", what);
        mismatches++;
    endtask

    task check_result(mexp_pkg::operand_t got);
        power_case_t c;
        if (expected_powers.size() == 0) begin
            report_mismatch($sformatf("unexpected result power_result=%0d", got));
        end else begin
            c = expected_powers.pop_front();
            results_checked++;
            if (got !== c.power)
                report_mismatch($sformatf(
                    "power_result got %0d expected %0d (base %0d exponent %0d modulus %0d)",
                    got, c.power, c.base_value, c.exponent, c.modulus));
        end
    endtask
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mexp_pkg::*;

    localparam real CLK_PERIOD = 12.0;
    localparam longint unsigned TIMEOUT_CYCLES = 3_500_000;
    localparam int HOLD_CYCLES = 1500;
    localparam int SETTLE_CYCLES = 2100;
    localparam int SEGMENTS = 9;
    localparam int SEGMENT_ITEMS = 30;
    localparam operand_t OPERAND_MAX = '1;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     cfg_wr_en = 1'b0;
    operand_t cfg_wr_data = '0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    operand_t s_base_value = '0;
    operand_t s_exponent = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    operand_t m_power_result;

    power_scoreboard sb = new();

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int moduli_written = 0;

    modular_exponentiation_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base_value  (s_base_value),
        .s_exponent    (s_exponent),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_power_result(m_power_result)
    );

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_item(s_base_value, s_exponent);
        if (aresetn && m_valid && m_ready) sb.check_result(m_power_result);
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(operand_t b, operand_t e);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_base_value = b;
        s_exponent = e;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_all_results();
        s_valid = 1'b0;
        while (sb.expected_powers.size() != 0) @(posedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_modulus(operand_t value);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.set_modulus(value);
        moduli_written++;
    endtask

    function automatic operand_t random_base(operand_t m);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return OPERAND_MAX;
            2: return m;
            3: return operand_t'($urandom_range(0, 15));
            4: return m - operand_t'(1);
            default: return operand_t'($urandom());
        endcase
    endfunction

    // many short exponents to keep the run short; full-width ones still frequent
    function automatic operand_t random_exponent();
        int len;
        len = $urandom_range(1, 31);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return operand_t'($urandom());
            4, 5, 6: return operand_t'($urandom()) & operand_t'((1 << $urandom_range(1, 12)) - 1);
            7: return operand_t'($urandom_range(0, 1));
            8: return operand_t'((64'd1 << len) - 1);
            default: return operand_t'(1) << $urandom_range(0, 30);
        endcase
    endfunction

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("modular_exponentiation_unit verification failed");
        $finish;
    end

    initial begin
        operand_t seg_modulus [SEGMENTS];
        int mode;

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed items against the reset modulus
        send_item('0, '0);
        send_item(OPERAND_MAX, '0);
        send_item('0, operand_t'(1));
        send_item('0, OPERAND_MAX);
        send_item(operand_t'(1), OPERAND_MAX);
        send_item(OPERAND_MAX, operand_t'(1));
        send_item(OPERAND_MAX, OPERAND_MAX);
        send_item(operand_t'(2), operand_t'(30));
        send_item(MODULUS_RESET, operand_t'(5));
        send_item(MODULUS_RESET + operand_t'(1), OPERAND_MAX);
        send_item(31'd2000000000, operand_t'(3));
        send_item(operand_t'(3), 31'h5555_5555);
        send_item(operand_t'(7), 31'h2AAA_AAAA);
        send_item(operand_t'(12345), MODULUS_RESET - operand_t'(1));
        wait_all_results();

        // modulus 1: zero exponent still gives 1
        write_modulus(operand_t'(1));
        send_item(operand_t'(7), '0);
        send_item(operand_t'(7), operand_t'(5));
        send_item(OPERAND_MAX, OPERAND_MAX);
        wait_all_results();

        // modulus 0 behaves as 1
        write_modulus('0);
        send_item(operand_t'(9), '0);
        send_item(operand_t'(9), operand_t'(3));
        send_item('0, '0);
        wait_all_results();

        seg_modulus[0] = OPERAND_MAX;
        seg_modulus[1] = operand_t'(2);
        seg_modulus[2] = operand_t'($urandom_range(1, 32'h7FFF_FFFF));
        seg_modulus[3] = MODULUS_RESET;
        seg_modulus[4] = operand_t'(3);
        seg_modulus[5] = operand_t'($urandom_range(2, 1000));
        seg_modulus[6] = '0;
        seg_modulus[7] = operand_t'($urandom());
        seg_modulus[8] = operand_t'(65537);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            mode = seg / 3;
            src_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 46 : 0;
            sink_idle_pct = (mode == 0) ? 46 : (mode == 1) ? 18 : 0;
            write_modulus(seg_modulus[seg]);
            for (int i = 0; i < SEGMENT_ITEMS; i++) begin
                if (seg == 1 && i == 10) begin
                    // receiver holds off while short items pile up behind the output
                    hold_request = 1'b1;
                    for (int k = 0; k < 5; k++)
                        send_item(random_base(seg_modulus[seg]),
                                  operand_t'($urandom_range(0, 15)));
                    wait_all_results();
                end else begin
                    send_item(random_base(seg_modulus[seg]), random_exponent());
                end
            end
            wait_all_results();
        end

        s_valid = 1'b0;
        while (sb.expected_powers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d items (%0d results checked) over %0d modulus writes,",
                 sb.items_noted, sb.results_checked, moduli_written);
        $display("with sender/receiver stalls, a %0d-cycle output hold-off and zero/one moduli.",
                 HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.expected_powers.size() == 0) begin
            $display("modular_exponentiation_unit verification clean");
        end else begin
            $display("modular_exponentiation_unit verification failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_datapath.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation_unit.sv
tb/tb_top.sv
